>>> hdl/tsst_pkg.sv
package tsst_pkg;

	// Table geometry
	localparam int SITE_COUNT  = 4096;
	localparam int SITE_W      = $clog2(SITE_COUNT);
	localparam int SLOT_W      = SITE_W + 1;
	localparam int WORD_BITS   = 64;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int PLANE_WORDS = SITE_COUNT / WORD_BITS;
	localparam int WORD_W      = $clog2(PLANE_WORDS);
	localparam int NET_W       = SLOT_W + 1;

	localparam logic [SLOT_W-1:0] NO_SLOT = '1;

	// Ternary state codes
	localparam logic [1:0] ST_ZERO = 2'b00;
	localparam logic [1:0] ST_POS  = 2'b01;
	localparam logic [1:0] ST_NEG  = 2'b11;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 280;

	typedef enum logic [1:0] {
		REQ_WRITE    = 2'd0,
		REQ_READ_SITE = 2'd1,
		REQ_READ_POS = 2'd2,
		REQ_CLEAR    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_TAIL_RD,
		S_TAIL_WR,
		S_POS,
		S_OUT,
		S_CLEAR
	} fsm_t;

	// Input beat, last declared field in the lowest bits
	typedef struct packed {
		logic [5:0]        pad;
		logic [SITE_W-1:0] list_position;
		logic signed [7:0] new_value;
		logic [SITE_W-1:0] site_index;
		req_t              req_type;
	} in_beat_t;

	// Result beat, last declared field in the lowest bits
	typedef struct packed {
		logic [6:0]           pad;
		logic [WORD_BITS-1:0] occupied_word;
		logic [WORD_BITS-1:0] negative_word;
		logic [WORD_BITS-1:0] positive_word;
		logic [SLOT_W-1:0]    active_total;
		logic signed [NET_W-1:0] net_sum;
		logic [SLOT_W-1:0]    contradicted_total;
		logic [SLOT_W-1:0]    supported_total;
		logic                 position_valid;
		logic [SITE_W-1:0]    entry_at_position;
		logic                 site_is_active;
		logic [SITE_W-1:0]    site_list_slot;
		logic signed [1:0]    site_state;
	} out_beat_t;

	// Per-site entry: state and back-pointer into the active list
	typedef struct packed {
		logic [1:0]        state;
		logic [SLOT_W-1:0] slot;
	} site_entry_t;

	// Plane word triple held in one memory row
	typedef struct packed {
		logic [WORD_BITS-1:0] occ;
		logic [WORD_BITS-1:0] neg;
		logic [WORD_BITS-1:0] pos;
	} plane_row_t;

endpackage

>>> hdl/ternary_sparse_set_table_unit.sv
// Ternary sparse-set table. Holds a state of -1, 0 or +1 for each of 4096 sites, kept in
// a site memory (state plus back-pointer), an active-list memory and a plane memory of
// 64-bit positive/negative/occupied words. Each request returns one result beat showing
// the table after the request. A read, or a write that needs no list move, steps through
// the READ, EVAL, POS and OUT states, and the next input beat is taken once the unit is
// back in IDLE. A removal that moves the list tail into the freed slot adds one extra
// read-modify-write of the tail's site entry (TAIL_RD, TAIL_WR). Clear walks the site
// memory one entry per cycle, then shows its result. After reset the same clearing pass
// runs and no input beat is taken until it ends. One request is in flight at a time; a
// finished result waits in the output register while the next request is taken, and a
// stalled result holds the following request at its last step.
module ternary_sparse_set_table_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// req_type[1:0], site_index[13:2], new_value[21:14], list_position[33:22], zero pad
	input  logic [tsst_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// site_state[1:0], site_list_slot[13:2], site_is_active[14], entry_at_position[26:15],
	// position_valid[27], supported_total[40:28], contradicted_total[53:41],
	// net_sum[67:54], active_total[80:68], positive_word[144:81],
	// negative_word[208:145], occupied_word[272:209], zero pad
	output logic [tsst_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	import tsst_pkg::*;

	in_beat_t in_beat;
	fsm_t     state_q, state_nx;

	// Request registers
	req_t              req_q;
	logic [SITE_W-1:0] site_q;
	logic [SITE_W-1:0] pos_q;
	logic [1:0]        sign_q;

	// Table totals
	logic [SLOT_W-1:0]       len_q, supp_q, contra_q;
	logic signed [NET_W-1:0] net_q;

	// Sequencer registers
	logic [SITE_W-1:0] clr_q;
	logic              init_q;
	logic [SITE_W-1:0] tail_q;
	logic [SLOT_W-1:0] slot_q;
	logic [1:0]        res_state_q;
	logic [SLOT_W-1:0] res_slot_q;
	plane_row_t        res_row_q;

	logic      m_valid_q;
	out_beat_t m_beat_q;

	// Memory ports
	logic              site_we;
	logic [SITE_W-1:0] site_waddr, site_raddr;
	site_entry_t       site_wdata, site_rd;
	logic              list_we;
	logic [SITE_W-1:0] list_waddr, list_raddr, list_wdata, list_rd;
	logic              plane_we;
	logic [WORD_W-1:0] plane_waddr;
	plane_row_t        plane_wdata, plane_rd;

	// Evaluation of a request
	logic [1:0]           new_state;
	logic                 is_write, changed, join_site, rem_site, move_tail, out_free;
	logic [SLOT_W-1:0]    new_slot;
	logic [WORD_BITS-1:0] bit_mask;
	plane_row_t           new_row;

	assign in_beat = in_beat_t'(s_axis_tdata);

	tsst_ram #(.WIDTH($bits(site_entry_t)), .DEPTH(SITE_COUNT)) u_site_ram (
		.clk   (clk),
		.we    (site_we),
		.waddr (site_waddr),
		.wdata (site_wdata),
		.raddr (site_raddr),
		.rdata (site_rd)
	);

	tsst_ram #(.WIDTH(SITE_W), .DEPTH(SITE_COUNT)) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rd)
	);

	tsst_ram #(.WIDTH($bits(plane_row_t)), .DEPTH(PLANE_WORDS)) u_plane_ram (
		.clk   (clk),
		.we    (plane_we),
		.waddr (plane_waddr),
		.wdata (plane_wdata),
		.raddr (site_q[SITE_W-1:BIT_W]),
		.rdata (plane_rd)
	);

	// Decide what a request does to the addressed site
	always_comb begin
		is_write  = (req_q == REQ_WRITE);
		new_state = is_write ? sign_q : site_rd.state;
		changed   = is_write && (sign_q != site_rd.state);
		join_site = changed && (site_rd.state == ST_ZERO);
		rem_site  = changed && (sign_q == ST_ZERO);
		move_tail = rem_site && (list_rd != site_q);
		if (join_site) begin
			new_slot = len_q;
		end else if (rem_site) begin
			new_slot = NO_SLOT;
		end else begin
			new_slot = site_rd.slot;
		end
		bit_mask    = WORD_BITS'(1) << site_q[BIT_W-1:0];
		new_row.pos = (plane_rd.pos & ~bit_mask) | ((new_state == ST_POS) ? bit_mask : '0);
		new_row.neg = (plane_rd.neg & ~bit_mask) | ((new_state == ST_NEG) ? bit_mask : '0);
		new_row.occ = (plane_rd.occ & ~bit_mask) | ((new_state != ST_ZERO) ? bit_mask : '0);
	end

	assign out_free = !m_valid_q || m_axis_tready;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:    if (s_axis_tvalid) state_nx = S_READ;
			S_READ:    state_nx = (req_q == REQ_CLEAR) ? S_CLEAR : S_EVAL;
			S_EVAL:    state_nx = move_tail ? S_TAIL_RD : S_POS;
			S_TAIL_RD: state_nx = S_TAIL_WR;
			S_TAIL_WR: state_nx = S_POS;
			S_POS:     state_nx = S_OUT;
			S_OUT:     if (out_free) state_nx = S_IDLE;
			S_CLEAR: begin
				if (clr_q == '1) begin
					state_nx = init_q ? S_IDLE : S_POS;
				end
			end
			default:   state_nx = S_IDLE;
		endcase
	end

	// Memory addressing and write strobes
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		site_raddr    = (state_q == S_TAIL_RD) ? tail_q : site_q;
		list_raddr    = (state_q == S_READ) ? SITE_W'(len_q - 1'b1) : pos_q;
		site_we       = 1'b0;
		site_waddr    = site_q;
		site_wdata    = '{state: new_state, slot: new_slot};
		list_we       = 1'b0;
		list_waddr    = len_q[SITE_W-1:0];
		list_wdata    = site_q;
		plane_we      = 1'b0;
		plane_waddr   = site_q[SITE_W-1:BIT_W];
		plane_wdata   = new_row;
		unique case (state_q)
			S_EVAL: begin
				site_we  = changed;
				plane_we = changed;
				list_we  = join_site || rem_site;
				if (rem_site) begin
					list_waddr = site_rd.slot[SITE_W-1:0];
					list_wdata = list_rd;
				end
			end
			S_TAIL_WR: begin
				site_we    = 1'b1;
				site_waddr = tail_q;
				site_wdata = '{state: site_rd.state, slot: slot_q};
			end
			S_CLEAR: begin
				site_we     = 1'b1;
				site_waddr  = clr_q;
				site_wdata  = '{state: ST_ZERO, slot: NO_SLOT};
				plane_we    = 1'b1;
				plane_waddr = clr_q[WORD_W-1:0];
				plane_wdata = '0;
			end
			default: ;
		endcase
	end

	// Control state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			init_q    <= 1'b1;
			clr_q     <= '0;
			len_q     <= '0;
			supp_q    <= '0;
			contra_q  <= '0;
			net_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR) begin
				clr_q    <= clr_q + 1'b1;
				len_q    <= '0;
				supp_q   <= '0;
				contra_q <= '0;
				net_q    <= '0;
				if (clr_q == '1) begin
					init_q <= 1'b0;
				end
			end
			if (state_q == S_EVAL && changed) begin
				supp_q   <= supp_q - SLOT_W'(site_rd.state == ST_POS)
				            + SLOT_W'(sign_q == ST_POS);
				contra_q <= contra_q - SLOT_W'(site_rd.state == ST_NEG)
				            + SLOT_W'(sign_q == ST_NEG);
				net_q    <= net_q - NET_W'(signed'(site_rd.state))
				            + NET_W'(signed'(sign_q));
				if (join_site) begin
					len_q <= len_q + 1'b1;
				end else if (rem_site) begin
					len_q <= len_q - 1'b1;
				end
			end
			// Hold a result until the beat is taken
			if (state_q == S_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, evaluation results and the output beat
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q  <= in_beat.req_type;
			site_q <= in_beat.site_index;
			pos_q  <= in_beat.list_position;
			if (in_beat.new_value == '0) begin
				sign_q <= ST_ZERO;
			end else if (in_beat.new_value[7]) begin
				sign_q <= ST_NEG;
			end else begin
				sign_q <= ST_POS;
			end
		end
		if (state_q == S_EVAL) begin
			tail_q      <= list_rd;
			slot_q      <= site_rd.slot;
			res_state_q <= new_state;
			res_slot_q  <= new_slot;
			res_row_q   <= new_row;
		end
		if (state_q == S_CLEAR) begin
			res_state_q <= ST_ZERO;
			res_slot_q  <= NO_SLOT;
			res_row_q   <= '0;
		end
		if (state_q == S_OUT && out_free) begin
			m_beat_q.pad                <= '0;
			m_beat_q.site_state         <= res_state_q;
			m_beat_q.site_is_active     <= (res_state_q != ST_ZERO);
			m_beat_q.site_list_slot     <= (res_state_q != ST_ZERO)
			                               ? res_slot_q[SITE_W-1:0] : '0;
			m_beat_q.position_valid     <= (SLOT_W'(pos_q) < len_q);
			m_beat_q.entry_at_position  <= (SLOT_W'(pos_q) < len_q) ? list_rd : '0;
			m_beat_q.supported_total    <= supp_q;
			m_beat_q.contradicted_total <= contra_q;
			m_beat_q.net_sum            <= net_q;
			m_beat_q.active_total       <= len_q;
			m_beat_q.positive_word      <= res_row_q.pos;
			m_beat_q.negative_word      <= res_row_q.neg;
			m_beat_q.occupied_word      <= res_row_q.occ;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_beat_q;

endmodule

>>> hdl/tsst_ram.sv
module tsst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/tsst_checker.sv
module tsst_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [tsst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	import tsst_pkg::*;

	out_beat_t beat;

	assign beat = out_beat_t'(m_axis_tdata);

	// Stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// One request at a time: ready drops after a taken input beat
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready stayed high after a taken beat");

	// Every active site is either supported or contradicted
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		({1'b0, beat.supported_total} + {1'b0, beat.contradicted_total})
		== {1'b0, beat.active_total})
		else $error("supported plus contradicted differs from active total");

	// Activity flag and list slot follow the site state
	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (beat.site_is_active == (beat.site_state != 2'sb00))
		&& (beat.site_state != 2'sb10)
		&& (beat.site_is_active || beat.site_list_slot == '0))
		else $error("site activity does not match its state");

	// Invalid position reads as zero
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !beat.position_valid |-> beat.entry_at_position == '0)
		else $error("entry shown for a position beyond the list");

endmodule

bind ternary_sparse_set_table_unit tsst_checker u_tsst_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tsst_pkg::*;

	// Mirror of the table: predicts one result beat per accepted request
	class ternary_table_mirror;
		int                  site_val [SITE_COUNT];
		logic [SITE_W-1:0]   live_list [SITE_COUNT];
		logic [SLOT_W-1:0]   back_slot [SITE_COUNT];
		logic [WORD_BITS-1:0] pos_plane [PLANE_WORDS];
		logic [WORD_BITS-1:0] neg_plane [PLANE_WORDS];
		logic [WORD_BITS-1:0] occ_plane [PLANE_WORDS];
		int                  list_len;
		int                  n_plus;
		int                  n_minus;
		int                  net;
		out_beat_t           due_results [$];
		int                  mismatches;

		function new();
			mismatches = 0;
			wipe_table();
		endfunction

		// Return every store and counter to its reset value
		function void wipe_table();
			for (int i = 0; i < SITE_COUNT; i++) begin
				site_val[i]  = 0;
				live_list[i] = '0;
				back_slot[i] = NO_SLOT;
			end
			for (int i = 0; i < PLANE_WORDS; i++) begin
				pos_plane[i] = '0;
				neg_plane[i] = '0;
				occ_plane[i] = '0;
			end
			list_len = 0;
			n_plus   = 0;
			n_minus  = 0;
			net      = 0;
		endfunction

		// Store a ternary value; keep list, planes and counters in step
		function void mirror_write(int site, int val);
			int prev;
			int w;
			int b;
			int slot;
			int tail;
			prev = site_val[site];
			w    = site / WORD_BITS;
			b    = site % WORD_BITS;
			if (prev == val)
				return;
			if (prev > 0)
				n_plus--;
			else if (prev < 0)
				n_minus--;
			net -= prev;
			if (prev == 0) begin
				back_slot[site]     = SLOT_W'(list_len);
				live_list[list_len] = SITE_W'(site);
				list_len++;
			end else if (val == 0) begin
				// move the tail entry into the freed slot
				slot = back_slot[site];
				tail = live_list[list_len - 1];
				live_list[slot] = SITE_W'(tail);
				back_slot[tail] = SLOT_W'(slot);
				list_len--;
				back_slot[site] = NO_SLOT;
			end
			site_val[site] = val;
			if (val > 0)
				n_plus++;
			else if (val < 0)
				n_minus++;
			net += val;
			pos_plane[w][b] = (val > 0);
			neg_plane[w][b] = (val < 0);
			occ_plane[w][b] = (val != 0);
		endfunction

		// Apply an accepted request and queue the result it must produce
		function void take_request(in_beat_t rq);
			out_beat_t exp_beat;
			int        site;
			int        w;
			int        val;
			site = rq.site_index;
			w    = site / WORD_BITS;
			if (rq.new_value == 0)
				val = 0;
			else if (rq.new_value < 0)
				val = -1;
			else
				val = 1;
			if (rq.req_type == REQ_WRITE)
				mirror_write(site, val);
			else if (rq.req_type == REQ_CLEAR)
				wipe_table();
			exp_beat                    = '0;
			exp_beat.site_state         = 2'(site_val[site]);
			exp_beat.site_is_active     = (site_val[site] != 0);
			exp_beat.site_list_slot     = (site_val[site] != 0) ?
				back_slot[site][SITE_W-1:0] : '0;
			if (rq.list_position < list_len) begin
				exp_beat.entry_at_position = live_list[rq.list_position];
				exp_beat.position_valid    = 1'b1;
			end
			exp_beat.supported_total    = SLOT_W'(n_plus);
			exp_beat.contradicted_total = SLOT_W'(n_minus);
			exp_beat.net_sum            = NET_W'(net);
			exp_beat.active_total       = SLOT_W'(list_len);
			exp_beat.positive_word      = pos_plane[w];
			exp_beat.negative_word      = neg_plane[w];
			exp_beat.occupied_word      = occ_plane[w];
			due_results.insert(due_results.size(), exp_beat);
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_field(string name, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		// Compare a result beat with the oldest queued prediction
		task match_result(logic [OUT_DATA_W-1:0] raw);
			out_beat_t got;
			out_beat_t want;
			got = out_beat_t'(raw);
			if (due_results.size() == 0) begin
				report("result beat with no request outstanding");
				return;
			end
			want = due_results.pop_front();
			check_field("site_state", 64'(got.site_state), 64'(want.site_state));
			check_field("site_list_slot", 64'(got.site_list_slot), 64'(want.site_list_slot));
			check_field("site_is_active", 64'(got.site_is_active), 64'(want.site_is_active));
			check_field("entry_at_position", 64'(got.entry_at_position),
				64'(want.entry_at_position));
			check_field("position_valid", 64'(got.position_valid), 64'(want.position_valid));
			check_field("supported_total", 64'(got.supported_total),
				64'(want.supported_total));
			check_field("contradicted_total", 64'(got.contradicted_total),
				64'(want.contradicted_total));
			check_field("net_sum", 64'(unsigned'(got.net_sum)), 64'(unsigned'(want.net_sum)));
			check_field("active_total", 64'(got.active_total), 64'(want.active_total));
			check_field("positive_word", got.positive_word, want.positive_word);
			check_field("negative_word", got.negative_word, want.negative_word);
			check_field("occupied_word", got.occupied_word, want.occupied_word);
			check_field("pad", 64'(got.pad), 64'(want.pad));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	ternary_table_mirror table_mirror = new();
	bit                  idle_on = 1'b1;
	int                  site_pool [32];

	ternary_sparse_set_table_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: check accepted beats, stall in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				table_mirror.match_result(m_axis_tdata);
			if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 14);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one request beat, hold it until taken, then maybe leave a gap
	task automatic send_req(req_t kind, int site, logic [7:0] raw_val, int pos);
		in_beat_t rq;
		int       gap;
		rq               = '0;
		rq.req_type      = kind;
		rq.site_index    = SITE_W'(site);
		rq.new_value     = raw_val;
		rq.list_position = SITE_W'(pos);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rq;
		do
			@(posedge clk);
		while (!s_axis_tready);
		table_mirror.take_request(rq);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Pick a fresh set of hot sites; half of them share one plane word
	task automatic refill_pool();
		int base;
		base = $urandom_range(0, PLANE_WORDS - 1) * WORD_BITS;
		for (int k = 0; k < 32; k++)
			site_pool[k] = (k < 16) ? base + $urandom_range(0, WORD_BITS - 1) :
				$urandom_range(0, SITE_COUNT - 1);
	endtask

	function automatic logic [7:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'sd0;
			3:       return 8'sd127;
			4:       return 8'h80;
			5:       return 8'sd1;
			6:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		int     spin;
		int     site;
		int     pos;
		int     roll;
		req_t   kind;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty reads, extremes, sign flips, unchanged and swap removals, clear
		send_req(REQ_READ_SITE, 0, 8'sd0, 0);
		send_req(REQ_READ_POS, 4095, 8'sd0, 4095);
		send_req(REQ_WRITE, 0, 8'sd127, 0);
		send_req(REQ_WRITE, 4095, 8'h80, 0);
		send_req(REQ_WRITE, 64, 8'sd1, 1);
		send_req(REQ_WRITE, 63, 8'hFF, 2);
		send_req(REQ_WRITE, 0, 8'sd5, 3);
		send_req(REQ_WRITE, 4095, 8'sd100, 4);
		send_req(REQ_READ_POS, 0, 8'sd0, 0);
		send_req(REQ_READ_POS, 0, 8'sd0, 3);
		send_req(REQ_READ_POS, 0, 8'sd0, 4);
		send_req(REQ_READ_POS, 4095, 8'hFF, 4095);
		send_req(REQ_WRITE, 4095, 8'sd0, 1);
		send_req(REQ_READ_SITE, 63, 8'sd0, 1);
		send_req(REQ_WRITE, 63, 8'sd0, 0);
		send_req(REQ_WRITE, 2000, 8'sd0, 0);
		send_req(REQ_READ_SITE, 64, 8'sd0, 1);
		send_req(REQ_WRITE, 4095, 8'hFF, 2);
		send_req(REQ_CLEAR, 4095, 8'sd0, 0);
		send_req(REQ_READ_SITE, 0, 8'sd0, 0);
		send_req(REQ_WRITE, 0, 8'hFF, 0);
		send_req(REQ_READ_POS, 0, 8'sd0, 0);

		// Random: mostly writes to a hot set so sites toggle and the list churns
		refill_pool();
		for (int i = 0; i < 1530; i++) begin
			if (i % 100 == 0) begin
				refill_pool();
				idle_on = ($urandom_range(0, 3) != 0);
			end
			if (i >= 1380)
				idle_on = 1'b0;
			roll = $urandom_range(0, 239);
			if (roll < 2)
				kind = REQ_CLEAR;
			else if (roll < 130)
				kind = REQ_WRITE;
			else if (roll < 180)
				kind = REQ_READ_SITE;
			else
				kind = REQ_READ_POS;
			site = ($urandom_range(0, 9) < 7) ? site_pool[$urandom_range(0, 31)] :
				$urandom_range(0, SITE_COUNT - 1);
			pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, table_mirror.list_len) :
				$urandom_range(0, SITE_COUNT - 1);
			send_req(kind, site, pick_value(), pos);
		end
		s_axis_tvalid <= 1'b0;

		// Drain outstanding results, then let the bench idle before the final check
		spin = 0;
		while (table_mirror.due_results.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		repeat (20) @(posedge clk);
		if (table_mirror.due_results.size() != 0)
			table_mirror.report($sformatf("%0d results never arrived",
				table_mirror.due_results.size()));
		if (table_mirror.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
